// ===== src/assert_macros.svh =====
// Assertion macros shared by the limiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define KBL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define KBL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/kbl_pkg.sv =====
// Types, constants and state codes of the keyed token bucket limiter.
`timescale 1ns / 1ps
package kbl_pkg;

    localparam int NUM_KEYS_DEFAULT = 256;

    localparam int RATE_W    = 16;
    localparam int TIME_W    = 64;
    localparam int TOKEN_W   = 52;
    localparam int ELAPSED_W = 36;
    localparam int PER_SEC_W = 46;
    localparam int SECS_W    = 6;
    localparam int DIV_W     = PER_SEC_W + SECS_W - 1;

    localparam logic [ELAPSED_W-1:0] UNITS_PER_TOKEN = 36'd60000000000;
    localparam logic [ELAPSED_W-1:0] NS_PER_MINUTE   = 36'd60000000000;
    localparam logic [ELAPSED_W-1:0] NS_PER_SECOND   = 36'd1000000000;
    localparam logic [RATE_W-1:0]    RPM_RESET       = 16'd60;
    localparam logic [SECS_W-1:0]    SECS_MAX        = 6'd60;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_EVICT   = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [7:0]        key_index;
        logic [TIME_W-1:0] now_ns;
    } kbl_in_t;

    typedef struct packed {
        logic              allowed;
        logic [SECS_W-1:0] retry_seconds;
    } kbl_out_t;

    typedef struct packed {
        logic               valid;
        logic [TOKEN_W-1:0] tokens;
        logic [TIME_W-1:0]  last_ns;
    } kbl_entry_t;

    typedef struct packed {
        logic              done;
        logic [SECS_W-1:0] secs;
    } kbl_div_res_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_REFILL,
        ST_UPDATE,
        ST_SPEND,
        ST_DIVIDE,
        ST_DONE
    } kbl_state_t;

endpackage

// ===== src/kbl_mem.sv =====
// Bucket table: one entry per key, one write and one registered read port.
`timescale 1ns / 1ps
module kbl_mem #(
    parameter int DEPTH = kbl_pkg::NUM_KEYS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  kbl_pkg::kbl_entry_t wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output kbl_pkg::kbl_entry_t rd_data
);
    import kbl_pkg::*;

    kbl_entry_t mem [DEPTH];
    kbl_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/kbl_retry_div.sv =====
// Restoring divider for the retry delay, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kbl_retry_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [kbl_pkg::PER_SEC_W-1:0] per_sec,
    input  logic [kbl_pkg::ELAPSED_W-1:0] deficit_m1,
    output kbl_pkg::kbl_div_res_t         res
);
    import kbl_pkg::*;

    localparam logic [2:0] LAST_STEP = 3'(SECS_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [2:0]           step_reg, step_next;
    logic [ELAPSED_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [SECS_W-1:0]    quo_reg, quo_next;
    logic                 fits;

    assign fits = {{(DIV_W - ELAPSED_W){1'b0}}, rem_reg} >= dvs_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = deficit_m1;
            dvs_next  = {per_sec, {(SECS_W - 1){1'b0}}};
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            // subtract the shifted divisor where it fits, shift in the quotient bit
            if (fits)
            begin
                rem_next = rem_reg - dvs_reg[ELAPSED_W-1:0];
            end
            quo_next  = {quo_reg[SECS_W-2:0], fits};
            dvs_next  = dvs_reg >> 1;
            step_next = step_reg + 3'd1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    // quotient of (deficit - 1) plus one is the rounded-up delay
    assign res.done = done_reg;
    assign res.secs = quo_reg + 6'd1;

    `KBL_ASSERT_IMP(a_no_restart, clk, rst_n, start, !busy_reg, "divider restarted while busy")
    `KBL_ASSERT_NXT(a_start_loads, clk, rst_n, start, busy_reg && step_reg == 3'd0, "start not taken")
    `KBL_ASSERT_NXT(a_last_step_done, clk, rst_n, busy_reg && step_reg == LAST_STEP && !start, done_reg && !busy_reg, "divider did not finish")

endmodule

// ===== src/keyed_token_bucket_limiter_core.sv =====
// Top level: request sequencer, refill datapath and result register of the limiter.
//
//  channel | signals                       | accepted when
//  --------+-------------------------------+-------------------------
//  request | in_valid, in_ready, in_data   | in_valid && in_ready
//  result  | out_valid, out_ready, out_data| out_valid && out_ready
//  config  | cfg_wr_en, cfg_wr_data        | cfg_wr_en
//
// An allowed acquire passes through the read, refill, update, spend and done states,
// a denied one through the divide state as well: the bucket table read, the shared
// 16x36 multiplier used three times and the six-step retry divider set these steps.
// Evict writes from idle; reset and clear sweep the table before a request is taken.
// A result waiting in the output register holds only the final step of the next acquire.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module keyed_token_bucket_limiter_core #(
    parameter int NUM_KEYS = kbl_pkg::NUM_KEYS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  kbl_pkg::kbl_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output kbl_pkg::kbl_out_t          out_data,
    input  logic                       cfg_wr_en,
    input  logic [kbl_pkg::RATE_W-1:0] cfg_wr_data
);
    import kbl_pkg::*;

    localparam int KEY_W = $clog2(NUM_KEYS);

    // fold the key into the table by at most eight conditional subtracts
    function automatic logic [KEY_W-1:0] key_mod(input logic [7:0] key);
        logic [31:0] rem;
        rem = {24'd0, key};
        for (int i = 7; i >= 0; i--)
        begin
            if (rem >= (32'(NUM_KEYS) << i))
            begin
                rem = rem - (32'(NUM_KEYS) << i);
            end
        end
        return rem[KEY_W-1:0];
    endfunction

    kbl_state_t state_reg, state_next;

    logic [RATE_W-1:0]    rpm_reg;
    logic [KEY_W-1:0]     sweep_idx_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [TIME_W-1:0]    now_reg;
    logic                 hit_reg;
    logic [TOKEN_W-1:0]   tokens_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [TOKEN_W-1:0]   prod_reg;
    logic [TOKEN_W-1:0]   cap_reg;
    logic [TOKEN_W-1:0]   level_reg;
    logic                 allowed_reg;
    logic [SECS_W-1:0]    secs_reg;
    logic                 out_valid_reg;
    kbl_out_t             out_data_reg;

    logic                 accept;
    logic [KEY_W-1:0]     in_key;
    logic                 sweep_last;
    logic [RATE_W-1:0]    rate;
    logic [ELAPSED_W-1:0] mul_b;
    logic [TOKEN_W-1:0]   mul_prod;
    logic [TIME_W-1:0]    time_diff;
    logic [ELAPSED_W-1:0] elapsed_c;
    logic [TOKEN_W:0]     sum_c;
    logic                 spend_ok;
    logic [TOKEN_W-1:0]   spend_level;

    logic                 in_ready_c;
    logic                 mem_wr_en;
    logic [KEY_W-1:0]     mem_wr_addr;
    kbl_entry_t           mem_wr_data;
    logic                 mem_rd_en;
    kbl_entry_t           mem_rd_data;
    logic                 div_start;
    logic [PER_SEC_W-1:0] div_per_sec;
    logic [ELAPSED_W-1:0] div_deficit_m1;
    kbl_div_res_t         div_res;
    logic                 out_load;

    assign accept     = in_valid && in_ready_c;
    assign in_key     = key_mod(in_data.key_index);
    assign sweep_last = sweep_idx_reg == KEY_W'(NUM_KEYS - 1);
    assign rate       = (rpm_reg == '0) ? RATE_W'(1) : rpm_reg;

    // shared multiplier: capacity, refill, then ns-per-second scaled by the rate
    always_comb
    begin
        case (state_reg)
            ST_READ:   mul_b = UNITS_PER_TOKEN;
            ST_REFILL: mul_b = elapsed_reg;
            default:   mul_b = NS_PER_SECOND;
        endcase
    end
    assign mul_prod = TOKEN_W'(rate) * TOKEN_W'(mul_b);

    // elapsed time, zero when time went backwards, clamped to one minute
    assign time_diff = now_reg - mem_rd_data.last_ns;
    always_comb
    begin
        if (now_reg <= mem_rd_data.last_ns)
        begin
            elapsed_c = '0;
        end
        else if (time_diff > TIME_W'(NS_PER_MINUTE))
        begin
            elapsed_c = NS_PER_MINUTE;
        end
        else
        begin
            elapsed_c = time_diff[ELAPSED_W-1:0];
        end
    end

    assign sum_c       = {1'b0, tokens_reg} + {1'b0, prod_reg};
    assign spend_ok    = level_reg >= TOKEN_W'(UNITS_PER_TOKEN);
    assign spend_level = spend_ok ? level_reg - TOKEN_W'(UNITS_PER_TOKEN) : level_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.operation)
                        OP_ACQUIRE: state_next = ST_READ;
                        OP_CLEAR:   state_next = ST_SWEEP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:   state_next = ST_REFILL;
            ST_REFILL: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_SPEND;
            ST_SPEND:  state_next = spend_ok ? ST_DONE : ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_res.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready_c  = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = key_reg;
        mem_wr_data = '{valid: 1'b0, tokens: '0, last_ns: '0};
        mem_rd_en   = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = sweep_idx_reg;
            end
            ST_IDLE:
            begin
                in_ready_c  = 1'b1;
                mem_wr_addr = in_key;
                mem_wr_en   = in_valid && in_data.operation == OP_EVICT;
                mem_rd_en   = in_valid && in_data.operation == OP_ACQUIRE;
            end
            ST_SPEND:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = '{valid: 1'b1, tokens: spend_level, last_ns: now_reg};
                div_start   = !spend_ok;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready_c = 1'b0;
            end
        endcase
    end

    assign div_per_sec    = prod_reg[PER_SEC_W-1:0];
    assign div_deficit_m1 = UNITS_PER_TOKEN - ELAPSED_W'(1) - level_reg[ELAPSED_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            rpm_reg       <= RPM_RESET;
            sweep_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                rpm_reg <= cfg_wr_data;
            end
            // advance the sweep, restart it on a clear request
            if (state_reg == ST_SWEEP)
            begin
                sweep_idx_reg <= sweep_last ? '0 : sweep_idx_reg + KEY_W'(1);
            end
            else if (accept)
            begin
                sweep_idx_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= in_key;
            now_reg <= in_data.now_ns;
        end
        case (state_reg)
            ST_READ:
            begin
                hit_reg     <= mem_rd_data.valid;
                tokens_reg  <= mem_rd_data.tokens;
                elapsed_reg <= elapsed_c;
                prod_reg    <= mul_prod;
            end
            ST_REFILL:
            begin
                cap_reg  <= prod_reg;
                prod_reg <= mul_prod;
            end
            ST_UPDATE:
            begin
                // a new entry starts full; the spend step takes its token
                if (!hit_reg || sum_c > {1'b0, cap_reg})
                begin
                    level_reg <= cap_reg;
                end
                else
                begin
                    level_reg <= sum_c[TOKEN_W-1:0];
                end
                prod_reg <= mul_prod;
            end
            ST_SPEND:
            begin
                allowed_reg <= spend_ok;
                secs_reg    <= '0;
            end
            ST_DIVIDE:
            begin
                if (div_res.done)
                begin
                    secs_reg <= div_res.secs;
                end
            end
            default:
            begin
                allowed_reg <= allowed_reg;
            end
        endcase
        if (out_load)
        begin
            out_data_reg <= '{allowed: allowed_reg, retry_seconds: secs_reg};
        end
    end

    kbl_mem #(
        .DEPTH (NUM_KEYS),
        .AW    (KEY_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (in_key),
        .rd_data (mem_rd_data)
    );

    kbl_retry_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .per_sec    (div_per_sec),
        .deficit_m1 (div_deficit_m1),
        .res        (div_res)
    );

    assign in_ready  = in_ready_c;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `KBL_ASSERT_IMP(a_spend_marks_valid, clk, rst_n, state_reg == ST_SPEND, mem_wr_en && mem_wr_data.valid, "spend did not write a valid entry")
    `KBL_ASSERT_NXT(a_acquire_reads, clk, rst_n, accept && in_data.operation == OP_ACQUIRE, state_reg == ST_READ, "acquire did not start a table read")
    `KBL_ASSERT_IMP(a_deny_secs_range, clk, rst_n, out_load && !allowed_reg, secs_reg != 6'd0 && secs_reg <= SECS_MAX, "retry delay out of range")
    `KBL_ASSERT_IMP(a_div_done_in_divide, clk, rst_n, div_res.done, state_reg == ST_DIVIDE, "divider finished outside divide state")

endmodule
